// ----- hw/rtl/stnsu_pkg.sv -----
// Shared types, register offsets and lookup tables for the square, triangle
// and noise sound unit. No dependencies.
`default_nettype none

package stnsu_pkg;

	// Item kind carried on s_tuser
	typedef enum logic [1:0] {
		MODE_WRITE  = 2'd0,
		MODE_TICK   = 2'd1,
		MODE_QFRAME = 2'd2
	} mode_t;

	// Register offsets from the unit's base
	localparam logic [4:0] ADDR_P1_CTRL  = 5'h00;
	localparam logic [4:0] ADDR_P1_SWEEP = 5'h01;
	localparam logic [4:0] ADDR_P1_LO    = 5'h02;
	localparam logic [4:0] ADDR_P1_HI    = 5'h03;
	localparam logic [4:0] ADDR_P2_CTRL  = 5'h04;
	localparam logic [4:0] ADDR_P2_SWEEP = 5'h05;
	localparam logic [4:0] ADDR_P2_LO    = 5'h06;
	localparam logic [4:0] ADDR_P2_HI    = 5'h07;
	localparam logic [4:0] ADDR_TRI_LIN  = 5'h08;
	localparam logic [4:0] ADDR_TRI_LO   = 5'h0A;
	localparam logic [4:0] ADDR_TRI_HI   = 5'h0B;
	localparam logic [4:0] ADDR_NOI_CTRL = 5'h0C;
	localparam logic [4:0] ADDR_NOI_PER  = 5'h0E;
	localparam logic [4:0] ADDR_NOI_LEN  = 5'h0F;
	localparam logic [4:0] ADDR_STATUS   = 5'h15;
	localparam logic [4:0] ADDR_FRAME    = 5'h17;

	// Largest audible pulse period, smallest audible one
	localparam logic [15:0] PULSE_PER_MAX = 16'h07FF;
	localparam logic [15:0] PULSE_PER_MIN = 16'd8;
	localparam logic [2:0]  SEQ_LAST      = 3'd4;

	// Fraction bits of the mixer's fixed-point terms
	localparam int MIX_FRAC = 58;
	localparam int MIX_W    = MIX_FRAC + 8;

	localparam logic [7:0] LEN_TAB [32] = '{
		8'd10, 8'd254, 8'd20, 8'd2, 8'd40, 8'd4, 8'd80, 8'd6,
		8'd160, 8'd8, 8'd60, 8'd10, 8'd14, 8'd12, 8'd26, 8'd14,
		8'd12, 8'd16, 8'd24, 8'd18, 8'd48, 8'd20, 8'd96, 8'd22,
		8'd192, 8'd24, 8'd72, 8'd26, 8'd16, 8'd28, 8'd32, 8'd30
	};

	// Bit k is the output at duty step k
	localparam logic [7:0] DUTY_TAB [4] = '{8'h02, 8'h06, 8'h1E, 8'hF9};

	localparam logic [11:0] NOISE_TAB [16] = '{
		12'd4, 12'd8, 12'd16, 12'd32, 12'd64, 12'd96, 12'd128, 12'd160,
		12'd202, 12'd254, 12'd380, 12'd508, 12'd762, 12'd1016, 12'd2034, 12'd4068
	};

	// Four gated channel levels
	typedef struct packed {
		logic [3:0] noise;
		logic [3:0] tri_lvl;
		logic [3:0] p2;
		logic [3:0] p1;
	} levels_t;

endpackage

`default_nettype wire

// ----- hw/rtl/stnsu_mix.sv -----
// Nonlinear mixer: pulse and triangle/noise terms from two constant tables.
// Depends on stnsu_pkg.
`default_nettype none

module stnsu_mix import stnsu_pkg::*; (
	input  wire levels_t    lv,
	output logic [7:0]      mixed
);

	logic [MIX_W-1:0] pul_tab [31];
	logic [MIX_W-1:0] tnd_tab [256];
	logic [4:0]       ps;
	logic [MIX_W:0]   sum;

	// Pulse term, truncated: 255*95.52*ps / (8128 + 100*ps)
	for (genvar i = 0; i < 31; i++) begin : g_pul
		localparam logic [127:0] NUM = (128'd2435760 * 128'(i)) << MIX_FRAC;
		localparam logic [127:0] DEN = 128'd100 * (128'd8128 + 128'd100 * 128'(i));
		localparam logic [127:0] VAL = NUM / DEN;
		assign pul_tab[i] = VAL[MIX_W-1:0];
	end

	// Triangle/noise term, rounded up so an exact integer sum stays exact
	for (genvar i = 0; i < 256; i++) begin : g_tnd
		localparam logic [127:0] S   = 128'd12241 * 128'(i / 16) + 128'd8227 * 128'(i % 16);
		localparam logic [127:0] NUM = (128'd4173585 * S) << MIX_FRAC;
		localparam logic [127:0] DEN = 128'd100 * (128'd100706707 + 128'd100 * S);
		localparam logic [127:0] VAL = (NUM + DEN - 128'd1) / DEN;
		assign tnd_tab[i] = VAL[MIX_W-1:0];
	end

	// Add both terms and keep the integer part
	assign ps    = 5'(lv.p1) + 5'(lv.p2);
	assign sum   = {1'b0, pul_tab[ps]} + {1'b0, tnd_tab[{lv.tri_lvl, lv.noise}]};
	assign mixed = sum[MIX_FRAC+7:MIX_FRAC];

endmodule

`default_nettype wire

// ----- hw/rtl/square_triangle_noise_sound_unit.sv -----
// Square, triangle and noise sound unit: channel state, item decode, output stage.
// Depends on stnsu_pkg and stnsu_mix.
// A result is registered in the channel state, then in the output register.
// Throughput: one item per cycle; s_tready follows the output register's space.
// Reset (arst_n low) clears all channel state, the noise shift register to one,
// and empties the pipeline.
`default_nettype none

module square_triangle_noise_sound_unit import stnsu_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [15:0] s_tdata,   // [4:0] address, [12:5] data, zero fill
	input  wire  [1:0]  s_tuser,   // [1:0] mode
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [23:0] m_tdata    // [3:0] pulse1_level, [7:4] pulse2_level,
	                               // [11:8] triangle_level, [15:12] noise_level,
	                               // [23:16] mixed_sample
);

	typedef struct packed {
		logic       start;
		logic       loop;
		logic       en;
		logic [3:0] vol;
		logic [3:0] cnt;
		logic [3:0] lvl;
	} env_t;

	typedef struct packed {
		logic       reload;
		logic       en;
		logic       neg;
		logic [2:0] shift;
		logic [3:0] rld;
		logic [3:0] cnt;
	} sweep_t;

	typedef struct packed {
		logic [3:0]       chan_en;
		logic [3:0]       len_en;
		logic [3:0][7:0]  len;
		logic [1:0][15:0] per;
		logic [1:0][15:0] ptmr;
		logic [1:0][1:0]  duty;
		logic [1:0][2:0]  dstep;
		sweep_t [1:0]     sw;
		env_t [2:0]       env;
		logic [10:0]      tper;
		logic [10:0]      ttmr;
		logic [4:0]       tstep;
		logic [6:0]       lin_rld;
		logic [6:0]       lin_cnt;
		logic             lin_flag;
		logic             nshort;
		logic [14:0]      lfsr;
		logic [11:0]      nper;
		logic [11:0]      ntmr;
		logic [2:0]       seq;
	} st_t;

	function automatic env_t env_clk(env_t e);
		env_t r;
		r = e;
		if (e.start) begin
			r.lvl   = 4'd15;
			r.cnt   = e.vol;
			r.start = 1'b0;
		end else if (e.cnt != 4'd0) begin
			r.cnt = e.cnt - 4'd1;
		end else begin
			if (e.lvl != 4'd0)
				r.lvl = e.lvl - 4'd1;
			else if (e.loop)
				r.lvl = 4'd15;
			r.cnt = e.vol;
		end
		return r;
	endfunction

	function automatic st_t clk_env_all(st_t s);
		st_t r;
		r = s;
		r.env[0] = env_clk(s.env[0]);
		r.env[1] = env_clk(s.env[1]);
		r.env[2] = env_clk(s.env[2]);
		if (s.lin_flag)
			r.lin_cnt = s.lin_rld;
		else if (s.lin_cnt != 7'd0)
			r.lin_cnt = s.lin_cnt - 7'd1;
		r.lin_flag = 1'b0;
		return r;
	endfunction

	function automatic logic [15:0] sweep_target(logic [15:0] per, sweep_t w, logic first);
		logic [15:0] delta;
		delta = per >> w.shift;
		if (w.neg)
			return per - delta - {15'd0, first};
		return per + delta;
	endfunction

	function automatic st_t clk_sweep_len(st_t s);
		st_t r;
		r = s;
		for (int p = 0; p < 2; p++) begin
			if (s.sw[p].reload) begin
				if (s.sw[p].en && s.sw[p].cnt == 4'd0)
					r.per[p] = sweep_target(s.per[p], s.sw[p], p == 0);
				r.sw[p].cnt    = s.sw[p].rld;
				r.sw[p].reload = 1'b0;
			end else if (s.sw[p].cnt != 4'd0) begin
				r.sw[p].cnt = s.sw[p].cnt - 4'd1;
			end else begin
				if (s.sw[p].en)
					r.per[p] = sweep_target(s.per[p], s.sw[p], p == 0);
				r.sw[p].cnt = s.sw[p].rld;
			end
		end
		for (int i = 0; i < 4; i++)
			if (s.len_en[i] && s.len[i] != 8'd0)
				r.len[i] = s.len[i] - 8'd1;
		return r;
	endfunction

	function automatic st_t tri_tick(st_t s);
		st_t r;
		r = s;
		if (s.ttmr == 11'd0) begin
			r.ttmr = s.tper;
			if (s.len[2] != 8'd0 && s.lin_cnt != 7'd0)
				r.tstep = s.tstep + 5'd1;
		end else begin
			r.ttmr = s.ttmr - 11'd1;
		end
		return r;
	endfunction

	function automatic logic [3:0] env_out(env_t e);
		return e.en ? e.lvl : e.vol;
	endfunction

	st_t        st_q, st_d;
	logic       v_s1;
	logic       xfer_in;
	logic       adv;
	mode_t      mode;
	logic [4:0] addr;
	logic [7:0] wdata;
	logic       pw;
	levels_t    lv;
	logic [7:0] mixed;
	logic [23:0] m_tdata_q;
	logic       m_tvalid_q;

	assign mode    = mode_t'(s_tuser);
	assign addr    = s_tdata[4:0];
	assign wdata   = s_tdata[12:5];
	assign pw      = addr[2];
	assign adv     = !m_tvalid_q || m_tready;
	assign s_tready = adv;
	assign xfer_in = s_tvalid && s_tready;

	// Next channel state for the item at the input
	always_comb begin
		st_d = st_q;
		case (mode)
			MODE_WRITE: begin
				unique case (addr)
					ADDR_P1_CTRL, ADDR_P2_CTRL: begin
						st_d.duty[pw]      = wdata[7:6];
						st_d.len_en[pw]    = !wdata[5];
						st_d.env[pw].start = 1'b1;
						st_d.env[pw].en    = !wdata[4];
						st_d.env[pw].loop  = wdata[5];
						st_d.env[pw].vol   = wdata[3:0];
					end
					ADDR_P1_SWEEP, ADDR_P2_SWEEP: begin
						st_d.sw[pw].reload = 1'b1;
						st_d.sw[pw].en     = wdata[7];
						st_d.sw[pw].neg    = wdata[3];
						st_d.sw[pw].rld    = {1'b0, wdata[6:4]} + 4'd1;
						st_d.sw[pw].shift  = wdata[2:0];
					end
					ADDR_P1_LO, ADDR_P2_LO: begin
						st_d.per[pw][7:0] = wdata;
					end
					ADDR_P1_HI, ADDR_P2_HI: begin
						st_d.len[pw]       = LEN_TAB[wdata[7:3]];
						st_d.per[pw]       = {5'd0, wdata[2:0], st_q.per[pw][7:0]};
						st_d.env[pw].start = 1'b1;
						st_d.dstep[pw]     = 3'd0;
					end
					ADDR_TRI_LIN: begin
						st_d.len_en[2] = !wdata[7];
						st_d.lin_rld   = wdata[6:0];
					end
					ADDR_TRI_LO: begin
						st_d.tper[7:0] = wdata;
					end
					ADDR_TRI_HI: begin
						st_d.len[2]    = LEN_TAB[wdata[7:3]];
						st_d.tper      = {wdata[2:0], st_q.tper[7:0]};
						st_d.ttmr      = {wdata[2:0], st_q.tper[7:0]};
						st_d.lin_flag  = 1'b1;
					end
					ADDR_NOI_CTRL: begin
						st_d.len_en[3]    = !wdata[5];
						st_d.env[2].start = 1'b1;
						st_d.env[2].en    = !wdata[4];
						st_d.env[2].loop  = wdata[5];
						st_d.env[2].vol   = wdata[3:0];
					end
					ADDR_NOI_PER: begin
						st_d.nshort = wdata[7];
						st_d.nper   = NOISE_TAB[wdata[3:0]];
					end
					ADDR_NOI_LEN: begin
						st_d.len[3]       = LEN_TAB[wdata[7:3]];
						st_d.env[2].start = 1'b1;
					end
					ADDR_STATUS: begin
						for (int i = 0; i < 4; i++) begin
							st_d.chan_en[i] = wdata[i];
							if (!wdata[i])
								st_d.len[i] = 8'd0;
						end
					end
					ADDR_FRAME: begin
						st_d = clk_sweep_len(clk_env_all(st_q));
					end
					default: begin
					end
				endcase
			end
			MODE_TICK: begin
				for (int p = 0; p < 2; p++) begin
					if (st_q.ptmr[p] == 16'd0) begin
						st_d.ptmr[p]  = st_q.per[p];
						st_d.dstep[p] = st_q.dstep[p] + 3'd1;
					end else begin
						st_d.ptmr[p] = st_q.ptmr[p] - 16'd1;
					end
				end
				if (st_q.ntmr == 12'd0) begin
					st_d.ntmr = st_q.nper;
					st_d.lfsr = {st_q.lfsr[0] ^ (st_q.nshort ? st_q.lfsr[6] : st_q.lfsr[1]),
					             st_q.lfsr[14:1]};
				end else begin
					st_d.ntmr = st_q.ntmr - 12'd1;
				end
				st_d = tri_tick(tri_tick(st_d));
			end
			MODE_QFRAME: begin
				// Odd steps clock envelopes only; the last step clocks nothing
				st_d.seq = (st_q.seq >= SEQ_LAST) ? 3'd0 : st_q.seq + 3'd1;
				if (st_d.seq[0])
					st_d = clk_env_all(st_d);
				else if (st_d.seq != SEQ_LAST)
					st_d = clk_sweep_len(clk_env_all(st_d));
			end
			default: begin
			end
		endcase
	end

	// Hold channel state; advance on each input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= '{lfsr: 15'd1, default: '0};
			v_s1      <= 1'b0;
		end else begin
			if (xfer_in)
				st_q <= st_d;
			if (adv)
				v_s1 <= xfer_in;
		end
	end

	// Gate the channel levels from the state left by the last item
	always_comb begin
		lv = '0;
		for (int p = 0; p < 2; p++) begin
			if (st_q.chan_en[p] && st_q.len[p] != 8'd0
			    && DUTY_TAB[st_q.duty[p]][st_q.dstep[p]]
			    && st_q.per[p] >= PULSE_PER_MIN && st_q.per[p] <= PULSE_PER_MAX) begin
				if (p == 0)
					lv.p1 = env_out(st_q.env[0]);
				else
					lv.p2 = env_out(st_q.env[1]);
			end
		end
		if (st_q.chan_en[2] && st_q.len[2] != 8'd0 && st_q.lin_cnt != 7'd0)
			lv.tri_lvl = st_q.tstep[4] ? st_q.tstep[3:0] : ~st_q.tstep[3:0];
		if (st_q.chan_en[3] && st_q.len[3] != 8'd0 && st_q.lfsr[0])
			lv.noise = env_out(st_q.env[2]);
	end

	stnsu_mix u_mix (
		.lv    (lv),
		.mixed (mixed)
	);

	// Output register: load a finished result when there is room
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (adv) begin
			m_tvalid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s1)
			m_tdata_q <= {mixed, lv};
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// Checks
	a_seq_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.seq <= SEQ_LAST) else $error("sequencer step out of range");

	a_lfsr_live: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.lfsr != 15'd0) else $error("noise shift register went to zero");

	a_s1_moves: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && adv |=> m_tvalid) else $error("result lost between stages");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !adv |=> v_s1 && $stable(st_q)) else $error("stalled stage changed");

endmodule

`default_nettype wire
